/* hw/rtl/kdtree_range_count_assert.svh */
// Assertion macros used by kdtree_range_count.sv.
`ifndef KDTREE_RANGE_COUNT_ASSERT_SVH
`define KDTREE_RANGE_COUNT_ASSERT_SVH

// Implication check on every rising clock edge, off during reset.
`define KRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define KRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/krc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package krc_pkg;

  localparam int unsigned MaxPoints  = 4096;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned IdxBits    = 12;
  localparam int unsigned SlotBits   = $clog2(MaxPoints);
  localparam int unsigned SpBits     = $clog2(StackDepth);
  localparam int unsigned CountBits  = 13;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [1:0] RegFirst = 2'd0;
  localparam logic [1:0] RegLast  = 2'd1;
  localparam logic [1:0] RegAxis  = 2'd2;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [IdxBits:0] sidx_t;

  typedef struct packed {
    coord_t xlo;
    coord_t ylo;
    coord_t xhi;
    coord_t yhi;
  } box_t;

  // One pending subtree: index span, axis, region.
  typedef struct packed {
    sidx_t lo;
    sidx_t hi;
    logic  axis;
    box_t  region;
  } frame_t;

  typedef struct packed {
    logic          kind;
    logic [11:0]   slot;
    coord_t        point_x;
    coord_t        point_y;
    coord_t        query_x_lo;
    coord_t        query_y_lo;
    coord_t        query_x_hi;
    coord_t        query_y_hi;
    coord_t        region_x_lo;
    coord_t        region_y_lo;
    coord_t        region_x_hi;
    coord_t        region_y_hi;
  } in_item_t;

  typedef struct packed {
    logic [CountBits-1:0] hit_count;
    logic                 stack_overflow;
  } out_item_t;

  // Point store write port.
  typedef struct packed {
    logic                en;
    logic [SlotBits-1:0] addr;
    coord_t              x;
    coord_t              y;
  } pt_wr_t;

  function automatic logic boxes_meet(box_t a, box_t b);
    boxes_meet = !((a.xhi < b.xlo) || (b.xhi < a.xlo) ||
                   (a.yhi < b.ylo) || (b.yhi < a.ylo));
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/kdtree_range_count.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Payload             | Handshake
// in      | input     | krc_pkg::in_item_t  | in_valid_i / in_ready_o
// out     | output    | krc_pkg::out_item_t | out_valid_o / out_ready_i
// cfg     | input     | 13-bit data, index  | cfg_we_i (no wait)
// A load is written while idle. A query pushes the root frame if its range is
// nonempty and its region meets the query; each popped subtree then takes a pop
// and a stack read, and one that meets the query also a point read, compare and
// first push, then a second push. A final empty pop leads to posting the result.
// Reset initialises control and result registers; the query, frame and memories
// keep no reset. A result waiting in the output register lets the next load
// through but holds the next query.
module kdtree_range_count (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire krc_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output krc_pkg::out_item_t       out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [12:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle, StPop, StRead, StEval, StPush2, StDone
  } state_e;

  state_e                       state_q;
  logic [11:0]                  first_q;
  krc_pkg::sidx_t               last_q;
  logic                         axis_q;
  krc_pkg::box_t                query_q;
  logic [krc_pkg::SpBits:0]     top_q;
  logic [krc_pkg::CountBits-1:0] count_q;
  logic                         ovf_q;
  krc_pkg::frame_t              cur_q;
  krc_pkg::frame_t              second_q;
  logic                         second_v_q;

  krc_pkg::pt_wr_t              pt_wr;
  krc_pkg::coord_t              px, py;
  logic                         st_we;
  logic [krc_pkg::SpBits-1:0]   st_wa;
  krc_pkg::frame_t              st_wd;
  krc_pkg::frame_t              st_rd;
  logic [krc_pkg::SpBits-1:0]   st_ra;

  logic                         in_xfer;
  krc_pkg::box_t                q_in, r_in, pt_box, low_box, high_box;
  krc_pkg::sidx_t               k, k_rd, first_s;
  logic                         low_ok, high_ok;
  krc_pkg::frame_t              low_f, high_f, f1, f2;
  logic                         f1_v, f2_v;

  assign in_ready_o = (state_q == StIdle) &&
                      (!out_valid_o || in_data_i.kind == krc_pkg::KindLoad);
  assign in_xfer = in_valid_i && in_ready_o;

  // Load writes go straight into the store.
  always_comb begin
    pt_wr.en   = in_xfer && (in_data_i.kind == krc_pkg::KindLoad);
    pt_wr.addr = in_data_i.slot[krc_pkg::SlotBits-1:0];
    pt_wr.x    = in_data_i.point_x;
    pt_wr.y    = in_data_i.point_y;
  end

  assign q_in = '{in_data_i.query_x_lo, in_data_i.query_y_lo,
                  in_data_i.query_x_hi, in_data_i.query_y_hi};
  assign r_in = '{in_data_i.region_x_lo, in_data_i.region_y_lo,
                  in_data_i.region_x_hi, in_data_i.region_y_hi};
  assign first_s = {1'b0, first_q};

  // Node of the frame being read, so its point is ready at evaluation.
  assign k_rd = krc_pkg::sidx_t'((14'(st_rd.lo) + 14'(st_rd.hi)) >> 1);

  // Node index and child frames.
  always_comb begin
    k        = krc_pkg::sidx_t'((14'(cur_q.lo) + 14'(cur_q.hi)) >> 1);
    pt_box   = '{px, py, px, py};
    low_box  = cur_q.region;
    high_box = cur_q.region;
    if (cur_q.axis) begin
      low_box.xhi  = px;
      high_box.xlo = px;
    end else begin
      low_box.yhi  = py;
      high_box.ylo = py;
    end
    low_ok  = (k > cur_q.lo) && krc_pkg::boxes_meet(query_q, low_box);
    high_ok = (k < cur_q.hi) && krc_pkg::boxes_meet(query_q, high_box);
    low_f   = '{cur_q.lo, k - 13'sd1, ~cur_q.axis, low_box};
    high_f  = '{k + 13'sd1, cur_q.hi, ~cur_q.axis, high_box};
    // First pushed goes first.
    if (cur_q.axis) begin
      f1 = high_f; f1_v = high_ok; f2 = low_f;  f2_v = low_ok;
    end else begin
      f1 = low_f;  f1_v = low_ok;  f2 = high_f; f2_v = high_ok;
    end
    if (!f1_v) begin
      f1 = f2; f1_v = f2_v; f2_v = 1'b0;
    end
  end

  // Stack write port.
  always_comb begin
    st_we = 1'b0;
    st_wa = top_q[krc_pkg::SpBits-1:0];
    st_wd = f1;
    unique case (state_q)
      StIdle: begin
        st_wd = '{first_s, last_q, axis_q, r_in};
        st_we = in_xfer && in_data_i.kind == krc_pkg::KindQuery &&
                (first_s <= last_q) && krc_pkg::boxes_meet(q_in, r_in);
      end
      StEval:  st_we = f1_v && !top_q[krc_pkg::SpBits];
      StPush2: begin
        st_wd = second_q;
        st_we = second_v_q && !top_q[krc_pkg::SpBits];
      end
      default: st_we = 1'b0;
    endcase
  end

  logic [krc_pkg::SpBits:0] top_m1;
  assign top_m1 = top_q - 1'b1;
  assign st_ra  = top_m1[krc_pkg::SpBits-1:0];

  krc_point_mem u_pt (
    .clk_i, .wr_i(pt_wr),
    .rd_addr_i(k_rd[krc_pkg::SlotBits-1:0]),
    .rd_x_o(px), .rd_y_o(py)
  );

  krc_stack_mem u_st (
    .clk_i, .we_i(st_we), .wa_i(st_wa), .wd_i(st_wd),
    .ra_i(st_ra), .rd_o(st_rd)
  );

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      first_q     <= '0;
      last_q      <= '1;
      axis_q      <= 1'b1;
      top_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
      second_v_q  <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          krc_pkg::RegFirst: first_q <= cfg_data_i[11:0];
          krc_pkg::RegLast:  last_q  <= krc_pkg::sidx_t'(cfg_data_i);
          krc_pkg::RegAxis:  axis_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer && in_data_i.kind == krc_pkg::KindQuery) begin
            query_q <= q_in;
            count_q <= '0;
            ovf_q   <= 1'b0;
            top_q   <= {{krc_pkg::SpBits{1'b0}}, st_we};
            state_q <= StPop;
          end
        end
        StPop: begin
          if (top_q == '0) begin
            state_q <= StDone;
          end else begin
            top_q   <= top_m1;
            state_q <= StRead;
          end
        end
        StRead: begin
          cur_q   <= st_rd;
          state_q <= krc_pkg::boxes_meet(query_q, st_rd.region) ? StEval : StPop;
        end
        StEval: begin
          // Point arrives now; node indices beyond the store wrap around its slots.
          if (krc_pkg::boxes_meet(pt_box, query_q) && count_q != krc_pkg::CountMax) begin
            count_q <= count_q + 1'b1;
          end
          if (f1_v) begin
            if (top_q[krc_pkg::SpBits]) ovf_q <= 1'b1;
            else top_q <= top_q + 1'b1;
          end
          second_q   <= f2;
          second_v_q <= f1_v && f2_v;
          state_q    <= StPush2;
        end
        StPush2: begin
          if (second_v_q) begin
            if (top_q[krc_pkg::SpBits]) ovf_q <= 1'b1;
            else top_q <= top_q + 1'b1;
          end
          second_v_q <= 1'b0;
          state_q    <= StPop;
        end
        StDone: begin
          out_valid_o <= 1'b1;
          out_data_o  <= '{count_q, ovf_q};
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`include "kdtree_range_count_assert.svh"

  `KRC_ASSERT_IMPL(a_top_bound, 1'b1, top_q <= krc_pkg::StackDepth, "stack top past depth")
  `KRC_ASSERT_NEXT(a_done_out, state_q == StDone, out_valid_o, "result not posted")
  `KRC_ASSERT_IMPL(a_no_query_busy, state_q != StIdle, !in_ready_o, "input taken while busy")

endmodule
`default_nettype wire

/* hw/rtl/krc_point_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module krc_point_mem (
  input  wire logic                          clk_i,
  input  wire krc_pkg::pt_wr_t               wr_i,
  input  wire logic [krc_pkg::SlotBits-1:0]  rd_addr_i,
  output krc_pkg::coord_t                    rd_x_o,
  output krc_pkg::coord_t                    rd_y_o
);

  logic [2*krc_pkg::CoordBits-1:0] mem_q [krc_pkg::MaxPoints];
  logic [2*krc_pkg::CoordBits-1:0] rd_q;

  // Write one point; read one point through a register.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= {wr_i.x, wr_i.y};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_x_o = rd_q[2*krc_pkg::CoordBits-1:krc_pkg::CoordBits];
  assign rd_y_o = rd_q[krc_pkg::CoordBits-1:0];

endmodule
`default_nettype wire

/* hw/rtl/krc_stack_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module krc_stack_mem (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [krc_pkg::SpBits-1:0]  wa_i,
  input  wire krc_pkg::frame_t             wd_i,
  input  wire logic [krc_pkg::SpBits-1:0]  ra_i,
  output krc_pkg::frame_t                  rd_o
);

  krc_pkg::frame_t mem_q [krc_pkg::StackDepth];

  // Hold pending subtrees, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd_o <= mem_q[ra_i];
  end

endmodule
`default_nettype wire
